// File: hdl/pos_pkg.sv
// package for the polyline offset stroke block: sequencer state type,
// field widths and the saturation helper
// no dependencies
package pos_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TanW   = CoordW + 1;
  localparam int unsigned WidthW = 31;
  localparam int unsigned AccW   = 64;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NORM  = 8'b0000_0010,
    S_SQR   = 8'b0000_0100,
    S_SQRT  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIVLD = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  // clamp a 34-bit signed sum to 32 bits
  function automatic logic [CoordW-1:0] sat32(input logic signed [CoordW+1:0] v);
    logic [CoordW-1:0] r;
    r = v[CoordW-1:0];
    if (!v[CoordW+1] && (v[CoordW] || v[CoordW-1])) begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v[CoordW+1] && !(v[CoordW] && v[CoordW-1])) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

// File: hdl/polyline_offset_stroke_top.sv
// polyline offset stroke: left and right stroke vertices of a centerline
// depends on pos_pkg
//
// channel  dir  tdata (low bit up)                          tlast          tuser
// in_      in   point_x, point_y, point_z (96 bits)         final_point    -
// out_     out  left_x, left_y, right_x, right_y, out_z     last_of_strip  degenerate
// cfg_     in   stroke_width (31 bits, write enable only)   -              -
//
// each vertex pair runs through one shared multiplier, 64-bit add and
// compare logic and a sequencer: normalise (up to 30 shifts), square, 32
// square root steps, two divisions and emit; a zero tangent goes straight
// to the emit state
// a strip's first point is only stored unless alone, later points take one pass and a
// closing point two; in_tready is high only while the sequencer is idle, the
// emit cycle stalls while the output register holds an unread result
// rst_n is synchronous; no clearing pass is needed after reset
module polyline_offset_stroke_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // point_x, point_y, point_z
  input  logic          in_tlast,   // final_point
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata,  // left_x, left_y, right_x, right_y, out_z
  output logic          out_tlast,  // last_of_strip
  output logic          out_tuser,  // degenerate
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data // stroke_width
);

  localparam int unsigned CW = pos_pkg::CoordW;
  localparam int unsigned TW = pos_pkg::TanW;
  localparam int unsigned AW = pos_pkg::AccW;
  localparam logic [30:0] WidthReset = 31'(64'd1 << FRAC_BITS);

  pos_pkg::state_t state_r;

  logic [30:0]   width_r;
  logic [1:0]    held_r;
  logic [CW-1:0] oldx_r, oldy_r, oldz_r, newx_r, newy_r, newz_r;
  logic [CW-1:0] curx_r, cury_r, curz_r;
  logic          fin_r;
  logic [CW-1:0] px_r, py_r, pz_r;
  logic          last_r, degen_r, txn_r, tyn_r;
  logic [TW-1:0] a_r [3];
  logic [AW-1:0] acc_r, prod_r, bit_r, res_r, rem_r, dsh_r;
  logic [4:0]    cnt_r;
  logic          comp_r;
  logic [31:0]   q_r, qx_r, qy_r;
  logic          out_valid_r;
  logic [159:0]  out_data_r;
  logic          out_last_r, out_degen_r;

  // input side decode
  logic          in_fire, start_job, emit_ok;
  logic [CW-1:0] in_x, in_y, in_z;
  assign in_x      = in_tdata[31:0];
  assign in_y      = in_tdata[63:32];
  assign in_z      = in_tdata[95:64];
  assign in_tready = (state_r == pos_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_ok   = !out_valid_r || out_tready;
  assign start_job = (in_fire && !(held_r == 2'd0 && !in_tlast)) ||
                     (state_r == pos_pkg::S_EMIT && emit_ok && !last_r && fin_r);

  // job operands: point, tangent, last mark
  logic [CW-1:0]        sel_px, sel_py, sel_pz, cx, cy, cz, bx, by, bz;
  logic signed [TW-1:0] tx, ty, tz;
  logic                 sel_last, sel_zero;
  always_comb begin
    if (state_r == pos_pkg::S_EMIT) begin
      cx = curx_r; cy = cury_r; cz = curz_r;
      bx = newx_r; by = newy_r; bz = newz_r;
      sel_px = curx_r; sel_py = cury_r; sel_pz = curz_r;
      sel_last = 1'b1;
      sel_zero = 1'b0;
    end else begin
      cx = in_x; cy = in_y; cz = in_z;
      bx = (held_r == 2'd1) ? newx_r : oldx_r;
      by = (held_r == 2'd1) ? newy_r : oldy_r;
      bz = (held_r == 2'd1) ? newz_r : oldz_r;
      sel_zero = (held_r == 2'd0);
      sel_px = sel_zero ? in_x : newx_r;
      sel_py = sel_zero ? in_y : newy_r;
      sel_pz = sel_zero ? in_z : newz_r;
      sel_last = sel_zero;
    end
    tx = $signed({cx[CW-1], cx}) - $signed({bx[CW-1], bx});
    ty = $signed({cy[CW-1], cy}) - $signed({by[CW-1], by});
    tz = $signed({cz[CW-1], cz}) - $signed({bz[CW-1], bz});
    if (sel_zero) begin
      tx = '0; ty = '0; tz = '0;
    end
  end

  // largest magnitude for normalising
  logic [TW-1:0] m01, mx;
  always_comb begin
    m01 = (a_r[0] > a_r[1]) ? a_r[0] : a_r[1];
    mx  = (m01 > a_r[2]) ? m01 : a_r[2];
  end

  // shared multiplier
  logic [1:0]    sq_idx;
  logic [31:0]   mul_a, mul_b;
  logic [AW-1:0] mul_p;
  always_comb begin
    sq_idx = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
    if (state_r == pos_pkg::S_MUL) begin
      mul_a = {1'b0, width_r};
      mul_b = comp_r ? a_r[0][31:0] : a_r[1][31:0];
    end else begin
      mul_a = a_r[sq_idx][31:0];
      mul_b = a_r[sq_idx][31:0];
    end
  end
  assign mul_p = AW'(mul_a) * AW'(mul_b);

  // add and compare logic for the square root and the division
  logic [AW-1:0] sq_try, div_diff;
  logic          sq_ge, div_ge;
  logic [31:0]   q_nxt;
  assign sq_try   = res_r + bit_r;
  assign sq_ge    = acc_r >= sq_try;
  assign div_ge   = rem_r >= dsh_r;
  assign div_diff = rem_r - dsh_r;
  assign q_nxt    = {q_r[30:0], div_ge};

  // vertex sums
  logic signed [TW-1:0]   offx, offy;
  logic signed [CW+1:0]   sx, sy, ox, oy;
  always_comb begin
    offx = tyn_r ? $signed({1'b0, qx_r}) : -$signed({1'b0, qx_r});
    offy = txn_r ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
    sx = $signed({{2{px_r[CW-1]}}, px_r});
    sy = $signed({{2{py_r[CW-1]}}, py_r});
    ox = $signed({offx[TW-1], offx});
    oy = $signed({offy[TW-1], offy});
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pos_pkg::S_IDLE;
      width_r     <= WidthReset;
      held_r      <= 2'd0;
      out_valid_r <= 1'b0;
      oldx_r <= '0; oldy_r <= '0; oldz_r <= '0;
      newx_r <= '0; newy_r <= '0; newz_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && state_r != pos_pkg::S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        pos_pkg::S_IDLE: begin
          if (in_fire) begin
            curx_r <= in_x; cury_r <= in_y; curz_r <= in_z;
            fin_r  <= in_tlast;
            if (held_r == 2'd0 && !in_tlast) begin
              newx_r <= in_x; newy_r <= in_y; newz_r <= in_z;
              held_r <= 2'd1;
            end
          end
        end
        pos_pkg::S_NORM: begin
          if (mx[TW-1] || mx[TW-2]) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
          end else if (!mx[TW-3]) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
          end else begin
            state_r <= pos_pkg::S_SQR;
            cnt_r   <= '0;
            acc_r   <= '0;
          end
        end
        pos_pkg::S_SQR: begin
          prod_r <= mul_p;
          if (cnt_r != 5'd0) acc_r <= acc_r + prod_r;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd3) begin
            state_r <= pos_pkg::S_SQRT;
            cnt_r   <= '0;
            bit_r   <= AW'(1) << (AW - 2);
            res_r   <= '0;
          end
        end
        pos_pkg::S_SQRT: begin
          if (sq_ge) begin
            acc_r <= acc_r - sq_try;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= pos_pkg::S_MUL;
            comp_r  <= 1'b0;
          end
        end
        pos_pkg::S_MUL: begin
          prod_r  <= mul_p;
          state_r <= pos_pkg::S_DIVLD;
        end
        pos_pkg::S_DIVLD: begin
          rem_r   <= prod_r + {32'd0, res_r[31:0]};
          dsh_r   <= {res_r[31:0], 32'd0};
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= pos_pkg::S_DIV;
        end
        pos_pkg::S_DIV: begin
          if (div_ge) rem_r <= div_diff;
          dsh_r <= dsh_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            if (!comp_r) begin
              qx_r    <= q_nxt;
              comp_r  <= 1'b1;
              state_r <= pos_pkg::S_MUL;
            end else begin
              qy_r    <= q_nxt;
              state_r <= pos_pkg::S_EMIT;
            end
          end
        end
        pos_pkg::S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {pz_r, pos_pkg::sat32(sy - oy), pos_pkg::sat32(sx - ox),
                            pos_pkg::sat32(sy + oy), pos_pkg::sat32(sx + ox)};
            out_last_r  <= last_r;
            out_degen_r <= degen_r;
            // the closing point's own pass follows directly
            if (last_r || !fin_r) begin
              state_r <= pos_pkg::S_IDLE;
            end
            if (last_r) begin
              held_r <= 2'd0;
            end else if (!fin_r) begin
              oldx_r <= newx_r; oldy_r <= newy_r; oldz_r <= newz_r;
              newx_r <= curx_r; newy_r <= cury_r; newz_r <= curz_r;
              held_r <= 2'd2;
            end
          end
        end
        default: state_r <= pos_pkg::S_IDLE;
      endcase
      // load a new vertex job
      if (start_job) begin
        px_r    <= sel_px; py_r <= sel_py; pz_r <= sel_pz;
        last_r  <= sel_last;
        txn_r   <= tx[TW-1];
        tyn_r   <= ty[TW-1];
        a_r[0]  <= tx[TW-1] ? TW'(-tx) : TW'(tx);
        a_r[1]  <= ty[TW-1] ? TW'(-ty) : TW'(ty);
        a_r[2]  <= tz[TW-1] ? TW'(-tz) : TW'(tz);
        degen_r <= (tx == 0) && (ty == 0) && (tz == 0);
        qx_r    <= '0;
        qy_r    <= '0;
        state_r <= ((tx == 0) && (ty == 0) && (tz == 0)) ? pos_pkg::S_EMIT
                                                          : pos_pkg::S_NORM;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_degen_r;

  // checks
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n) held_r != 2'd3)
    else $error("held point count out of range");
  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pos_pkg::S_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost");
  a_len_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pos_pkg::S_MUL |-> res_r[31:30] != 2'd0)
    else $error("tangent length not normalised");
  a_degen_vert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |-> out_data_r[63:0] == out_data_r[127:64])
    else $error("degenerate result with split vertices");

endmodule

// File: dv/polyline_offset_stroke_top_test.sv
// testbench for the polyline offset stroke block: streams centerline strips,
// predicts stroke vertices and checks every result; depends on the rtl
module polyline_offset_stroke_top_test;

  typedef struct packed {
    logic [31:0] lx, ly, rx, ry, z;
    logic        degen, last;
  } vertex_pair_t;

  // scoreboard: stroke vertex predictor and queue of pending vertex pairs
  class stroke_scoreboard;
    logic signed [63:0] older_pt [3];
    logic signed [63:0] newer_pt [3];
    int unsigned        held;
    logic [63:0]        width;
    vertex_pair_t       pending [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        degen_seen;
    int unsigned        sat_seen;

    function void clear();
      for (int i = 0; i < 3; i++) begin
        older_pt[i] = 0;
        newer_pt[i] = 0;
      end
      held = 0;
      width = 64'd65536;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] clamp(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function vertex_pair_t stroke(logic signed [63:0] p [3], logic signed [63:0] t [3],
                                  bit last);
      vertex_pair_t r;
      logic signed [63:0] offx, offy;
      logic [63:0] a [3];
      logic [63:0] m, s, len, qx, qy;
      offx = 0;
      offy = 0;
      r.degen = (t[0] == 0 && t[1] == 0 && t[2] == 0);
      if (!r.degen) begin
        for (int i = 0; i < 3; i++) a[i] = t[i] < 0 ? -t[i] : t[i];
        m = a[0];
        if (a[1] > m) m = a[1];
        if (a[2] > m) m = a[2];
        // normalise so the largest magnitude sits in [2^30, 2^31)
        while (m >= (64'd1 << 31)) begin
          m >>= 1;
          for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < (64'd1 << 30)) begin
          m <<= 1;
          for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = int_sqrt(s);
        qx = (width * a[1] + len) / (2 * len);
        qy = (width * a[0] + len) / (2 * len);
        offx = t[1] < 0 ? $signed(qx) : -$signed(qx);
        offy = t[0] < 0 ? -$signed(qy) : $signed(qy);
      end
      r.lx = clamp(p[0] + offx);
      r.ly = clamp(p[1] + offy);
      r.rx = clamp(p[0] - offx);
      r.ry = clamp(p[1] - offy);
      r.z = p[2][31:0];
      r.last = last;
      return r;
    endfunction

    // note an accepted point request
    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
      logic signed [63:0] cur [3];
      logic signed [63:0] t [3];
      cur[0] = $signed(x);
      cur[1] = $signed(y);
      cur[2] = $signed(z);
      if (held == 0) begin
        if (fin) begin
          for (int i = 0; i < 3; i++) t[i] = 0;
          pending = {pending, stroke(cur, t, 1)};
        end else begin
          newer_pt = cur;
          held = 1;
        end
        return;
      end
      for (int i = 0; i < 3; i++)
        t[i] = held == 1 ? cur[i] - newer_pt[i] : cur[i] - older_pt[i];
      pending = {pending, stroke(newer_pt, t, 0)};
      if (fin) begin
        for (int i = 0; i < 3; i++) t[i] = cur[i] - newer_pt[i];
        pending = {pending, stroke(cur, t, 1)};
        held = 0;
      end else begin
        older_pt = newer_pt;
        newer_pt = cur;
        held = 2;
      end
    endfunction

    function void report(string field, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s expected %h actual %h", $time, field, e, a);
      errors++;
    endfunction

    // compare one result with the oldest expectation
    function void check_result(vertex_pair_t got);
      vertex_pair_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.degen) degen_seen++;
      if (exp_r.lx == 32'h7fffffff || exp_r.lx == 32'h80000000 ||
          exp_r.ry == 32'h7fffffff || exp_r.ry == 32'h80000000) sat_seen++;
      if (got.lx !== exp_r.lx) report("left_x", exp_r.lx, got.lx);
      if (got.ly !== exp_r.ly) report("left_y", exp_r.ly, got.ly);
      if (got.rx !== exp_r.rx) report("right_x", exp_r.rx, got.rx);
      if (got.ry !== exp_r.ry) report("right_y", exp_r.ry, got.ry);
      if (got.z !== exp_r.z) report("out_z", exp_r.z, got.z);
      if (got.degen !== exp_r.degen) report("degenerate", exp_r.degen, got.degen);
      if (got.last !== exp_r.last) report("last_of_strip", exp_r.last, got.last);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [159:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;
  logic         cfg_wr_en = 0;
  logic [30:0]  cfg_wr_data = '0;

  stroke_scoreboard sb;
  bit  quiet_tail = 0;
  bit  hold_sink = 0;
  int  points_sent = 0;

  always #2 clk = ~clk;

  polyline_offset_stroke_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // result side: random stalls, long hold when asked, checks each accepted result
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result({out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                         out_tdata[127:96], out_tdata[159:128], out_tuser, out_tlast});
      if (hold_sink) begin
        out_tready <= 0;
        for (int i = 0; i < 3000; i++) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 15);
        out_tready <= 0;
        for (int i = 1; i < gap; i++) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  // send one point, waiting for acceptance
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {z, y, x};
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_point(x, y, z, fin);
    points_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_width(logic [30:0] w);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.width = w;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
    endcase
  endfunction

  // one strip of random length with points mostly near each other
  task automatic random_strip(int len);
    logic [31:0] x, y, z;
    x = rand_coord();
    y = rand_coord();
    z = rand_coord();
    for (int i = 0; i < len; i++) begin
      send_point(x, y, z, i == len - 1);
      case ($urandom_range(0, 7))
        0: ; // repeated point, may give a zero tangent
        1: begin
          x = rand_coord();
          y = rand_coord();
          z = rand_coord();
        end
        default: begin
          x += $urandom_range(0, 32'h3ffff) - 32'h20000;
          y += $urandom_range(0, 32'h3ffff) - 32'h20000;
          if ($urandom_range(0, 1)) z += $urandom_range(0, 32'hffff) - 32'h8000;
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single point, extremes, repeated points, saturation
    send_point(32'h00010000, 32'h00020000, 32'h00030000, 1);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h00000000, 1);
    send_point(32'h00000000, 32'h00000000, 32'h00000000, 0);
    send_point(32'h00000000, 32'h00000000, 32'h00000000, 0);
    send_point(32'h00000000, 32'h00000000, 32'h00000001, 1);
    send_point(32'h00000000, 32'h00000000, 32'h00000000, 0);
    send_point(32'h00000001, 32'h00000000, 32'h00000000, 0);
    send_point(32'h00000001, 32'hffffffff, 32'h00000000, 1);
    send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
    set_width(31'h7fffffff);
    send_point(32'h7ff00000, 32'h00000000, 32'h0, 0);
    send_point(32'h7ff00000, 32'h00010000, 32'h0, 0);
    send_point(32'h80100000, 32'h00020000, 32'h0, 1);
    send_point(32'h00000000, 32'h00000000, 32'h0, 0);
    send_point(32'h00010000, 32'h00010000, 32'h0, 1);
    set_width(31'd0);
    send_point(32'h00000000, 32'h00000000, 32'h0, 0);
    send_point(32'h00050000, 32'hfffb0000, 32'h5, 1);

    // random strips under several widths
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_width(31'd65536);
        1: set_width(31'($urandom_range(1, 31'h7fffffff)));
        2: set_width(31'($urandom_range(1, 31'h000fffff)));
        3: set_width(31'h7fffffff);
        default: set_width(31'd131072);
      endcase
      if (phase == 2) hold_sink = 1;
      while (points_sent < 170 * (phase + 1)) begin
        if (phase == 4 && points_sent > 780) quiet_tail = 1;
        random_strip($urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 12));
      end
      if (phase == 1) drain();
    end

    drain();
    $display("covered %0d points, %0d results, %0d degenerate, %0d saturated vertices",
             points_sent, sb.checked, sb.degen_seen, sb.sat_seen);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // overall limit
  initial begin
    #4000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
